// ===== rtl/core/camera_flash_sequencer_macros.svh =====
// Assertion macros for the flash sequencer checker.
`ifndef CAMERA_FLASH_SEQUENCER_MACROS_SVH
`define CAMERA_FLASH_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flash sequencer check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flash sequencer check failed");

`endif

// ===== rtl/core/cfs_pkg.sv =====
// Types and constants of the camera flash sequencer.
`default_nettype none

package cfs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WAIT = 3'd1,
        PH_NOFL = 3'd2,
        PH_TAF  = 3'd3,
        PH_PRE  = 3'd4,
        PH_MAIN = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        LK_LOCKED  = 2'd0,
        LK_TAF     = 2'd1,
        LK_PRE_AF  = 2'd2,
        LK_PRE_NAF = 2'd3
    } lock_t;

    localparam logic [1:0] MODE_AUTO = 2'd1;
    localparam logic [1:0] MODE_ON   = 2'd2;

    localparam logic [7:0] AE_S1_RUNNING = 8'h12;
    localparam logic [7:0] AF_S1_OK      = 8'h10;
    localparam logic [7:0] AF_S1_FAIL    = 8'h11;
    localparam logic [7:0] UNDECIDED     = 8'd2;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY    = 1'd1;

    typedef struct packed {
        phase_t phase;
        lock_t  lock;
        logic   lit;
    } state_t;

    typedef struct packed {
        phase_t phase;
        lock_t  lock;
        logic   torch_on;
        logic   torch_off;
        logic   lit;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfs_step.sv =====
// Next-state and result logic for one transferred item.
`default_nettype none

module cfs_step (
    input  var cfs_pkg::state_t  cur,
    input  wire logic [1:0]      strobe_mode,
    input  wire logic            primary_sensor,
    input  wire logic            kind,
    input  wire logic [1:0]      arm_lock,
    input  wire logic [7:0]      ae_converge,
    input  wire logic [7:0]      ae_cal_ready,
    input  wire logic [7:0]      ae_flash_flag,
    input  wire logic [7:0]      af_assist_flag,
    input  wire logic [7:0]      af_converge,
    input  wire logic [7:0]      preflash_cal_ready,
    input  wire logic [7:0]      preflash_state,
    input  wire logic [7:0]      main_energy,
    output cfs_pkg::state_t      nxt,
    output cfs_pkg::result_t     res
);

    logic ae_running;
    logic af_done;
    logic decided;
    logic want;
    logic need;
    logic mode_on;
    logic mode_auto;
    logic wait_af;
    logic pf_ready;
    logic on_p;
    logic off_p;

    assign ae_running = (ae_converge == cfs_pkg::AE_S1_RUNNING);
    assign af_done    = af_converge inside {cfs_pkg::AF_S1_OK, cfs_pkg::AF_S1_FAIL};
    assign decided    = !(ae_running || (ae_cal_ready == 8'd0)
                          || (af_assist_flag == cfs_pkg::UNDECIDED)
                          || (ae_flash_flag == cfs_pkg::UNDECIDED));
    assign want       = (af_assist_flag != 8'd0) || (ae_flash_flag != 8'd0);
    assign mode_on    = (strobe_mode == cfs_pkg::MODE_ON);
    assign mode_auto  = (strobe_mode == cfs_pkg::MODE_AUTO);
    // Touch AF fires only on demand; otherwise forced mode always fires.
    assign need       = (cur.lock == cfs_pkg::LK_TAF) ? ((mode_on || mode_auto) && want)
                                                       : (mode_on || (mode_auto && want));
    assign wait_af    = ((cur.lock == cfs_pkg::LK_PRE_AF) || (cur.lock == cfs_pkg::LK_TAF))
                        && !af_done;
    assign pf_ready   = (preflash_cal_ready != 8'd0) && (preflash_state != 8'd0)
                        && (main_energy != 8'd0);

    always_comb
    begin
        nxt   = cur;
        on_p  = 1'b0;
        off_p = 1'b0;
        if (kind)
        begin
            nxt.lock  = cfs_pkg::lock_t'(arm_lock);
            nxt.phase = cfs_pkg::PH_IDLE;
        end
        else
        begin
            if (!primary_sensor)
            begin
                nxt.lock = cfs_pkg::LK_LOCKED;
            end
            if (nxt.lock != cfs_pkg::LK_LOCKED)
            begin
                case (cur.phase)
                    cfs_pkg::PH_IDLE:
                    begin
                        if (ae_running)
                        begin
                            nxt.phase = cfs_pkg::PH_WAIT;
                        end
                    end
                    cfs_pkg::PH_WAIT:
                    begin
                        if (decided)
                        begin
                            if (need)
                            begin
                                on_p      = 1'b1;
                                nxt.lit   = 1'b1;
                                nxt.phase = (cur.lock == cfs_pkg::LK_TAF) ? cfs_pkg::PH_TAF
                                                                          : cfs_pkg::PH_PRE;
                            end
                            else if (af_done)
                            begin
                                nxt.phase = cfs_pkg::PH_IDLE;
                                nxt.lock  = cfs_pkg::LK_LOCKED;
                            end
                            else
                            begin
                                nxt.phase = cfs_pkg::PH_NOFL;
                            end
                        end
                    end
                    cfs_pkg::PH_NOFL:
                    begin
                        if (af_done)
                        begin
                            nxt.phase = cfs_pkg::PH_IDLE;
                            nxt.lock  = cfs_pkg::LK_LOCKED;
                        end
                    end
                    cfs_pkg::PH_TAF, cfs_pkg::PH_PRE:
                    begin
                        if (!wait_af && pf_ready)
                        begin
                            if (cur.phase == cfs_pkg::PH_TAF)
                            begin
                                // Touch AF calibration done: drop the torch.
                                off_p     = 1'b1;
                                nxt.lit   = 1'b0;
                                nxt.phase = cfs_pkg::PH_IDLE;
                            end
                            else
                            begin
                                nxt.phase = cfs_pkg::PH_MAIN;
                            end
                            nxt.lock = cfs_pkg::LK_LOCKED;
                        end
                    end
                    default:
                    begin
                        // Main flash and unused codes hold until the next arm.
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.phase     = nxt.phase;
        res.lock      = nxt.lock;
        res.torch_on  = on_p;
        res.torch_off = off_p;
        res.lit       = nxt.lit;
    end

endmodule

`default_nettype wire

// ===== rtl/core/camera_flash_sequencer.sv =====
// Top level of the camera flash sequencer.
`default_nettype none

// Camera flash sequencer: takes one item per transfer (frame metadata or an
// arm command) and returns exactly one result per item, carrying the phase,
// lock cause and torch state after that item plus torch on/off pulses. The
// block sustains one item per clock cycle while out_ready is high; a result
// appears in the output register in the cycle after its input transfer. in_ready
// stays high whenever the output register is empty or is being drained in the same
// cycle, so throughput is set only by the consumer's out_ready. Configuration writes
// (strobe mode at index 0, primary_sensor at index 1) take effect at the next
// clock edge and must be issued while no item is in flight.
module camera_flash_sequencer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [1:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [1:0] arm_lock,
    input  wire logic [7:0] ae_converge,
    input  wire logic [7:0] ae_cal_ready,
    input  wire logic [7:0] ae_flash_flag,
    input  wire logic [7:0] af_assist_flag,
    input  wire logic [7:0] af_converge,
    input  wire logic [7:0] preflash_cal_ready,
    input  wire logic [7:0] preflash_state,
    input  wire logic [7:0] main_energy,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      phase,
    output logic [1:0]      lock_out,
    output logic            torch_on_cmd,
    output logic            torch_off_cmd,
    output logic            flash_lit
);

    logic [1:0]       strobe_mode_reg;
    logic             primary_reg;
    cfs_pkg::state_t  state_reg;
    cfs_pkg::state_t  state_next;
    cfs_pkg::result_t res_next;
    cfs_pkg::result_t res_reg;
    logic             out_valid_reg;
    logic             in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_mode_reg <= 2'd0;
            primary_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfs_pkg::CFG_FLASH_MODE: strobe_mode_reg <= cfg_data;
                cfs_pkg::CFG_PRIMARY:    primary_reg     <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    cfs_step u_step (
        .cur                (state_reg),
        .strobe_mode        (strobe_mode_reg),
        .primary_sensor     (primary_reg),
        .kind               (kind),
        .arm_lock           (arm_lock),
        .ae_converge        (ae_converge),
        .ae_cal_ready       (ae_cal_ready),
        .ae_flash_flag      (ae_flash_flag),
        .af_assist_flag     (af_assist_flag),
        .af_converge        (af_converge),
        .preflash_cal_ready (preflash_cal_ready),
        .preflash_state     (preflash_state),
        .main_energy        (main_energy),
        .nxt                (state_next),
        .res                (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= cfs_pkg::PH_IDLE;
            state_reg.lock  <= cfs_pkg::LK_LOCKED;
            state_reg.lit   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload register: load on every input transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = res_reg.phase;
    assign lock_out      = res_reg.lock;
    assign torch_on_cmd  = res_reg.torch_on;
    assign torch_off_cmd = res_reg.torch_off;
    assign flash_lit     = res_reg.lit;

endmodule

`default_nettype wire

// ===== rtl/core/cfs_checker.sv =====
// Port-level checker for the camera flash sequencer, bound to the top level.
`default_nettype none

`include "camera_flash_sequencer_macros.svh"

module cfs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] phase,
    input wire logic [1:0] lock_out,
    input wire logic       torch_on_cmd,
    input wire logic       torch_off_cmd,
    input wire logic       flash_lit
);

    // A stalled result must hold until the consumer takes it.
    `CFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(phase) && $stable(lock_out) && $stable(flash_lit))

    // Torch on leaves the torch lit in a flash phase.
    `CFS_ASSERT_NOW(a_on_cmd, out_valid && torch_on_cmd, flash_lit && !torch_off_cmd && (phase == cfs_pkg::PH_TAF || phase == cfs_pkg::PH_PRE))

    // Torch off ends touch AF: idle, dark and locked.
    `CFS_ASSERT_NOW(a_off_cmd, out_valid && torch_off_cmd, !flash_lit && phase == cfs_pkg::PH_IDLE && lock_out == cfs_pkg::LK_LOCKED)

    // Back pressure only comes from a pending result.
    `CFS_ASSERT_NOW(a_ready, !in_ready, out_valid && !out_ready)

endmodule

bind camera_flash_sequencer cfs_checker u_cfs_checker (.*);

`default_nettype wire
